[design/shfr_pkg.sv]
// ----------------------------------------------------------------------------
// shfr_pkg
// Shared types and constants of the sync header frame receiver.
// ----------------------------------------------------------------------------
package shfr_pkg;

	localparam int unsigned HdrLen    = 5;
	localparam int unsigned OutDataW  = 48;

	// register indexes of the configuration port
	localparam logic CFG_SYNC_FIRST  = 1'b0;
	localparam logic CFG_SYNC_SECOND = 1'b1;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
	} sync_cfg_t;

	// one pending result between the front and the back
	typedef struct packed {
		logic        frame_end;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [7:0]  frame_type;
		logic [7:0]  destination;
		logic [7:0]  payload_length;
		logic [15:0] trailer;
		logic [15:0] byte_sum;
	} result_entry_t;

	typedef struct packed {
		logic       full;
		logic [1:0] level;
	} queue_status_t;

endpackage

[design/shfr_front.sv]
// ----------------------------------------------------------------------------
// shfr_front
// Accept link bytes, hunt for the sync pair, track the frame layout and the
// running byte sum, and push one result entry for each payload byte and
// for each frame end.
// ----------------------------------------------------------------------------
module shfr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  shfr_pkg::sync_cfg_t     cfg,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,
	input  logic                    queue_full,
	output logic                    push_valid,
	output shfr_pkg::result_entry_t push_entry
);
	import shfr_pkg::*;

	typedef enum logic [1:0] {
		ST_HUNT  = 2'b01,
		ST_FRAME = 2'b10
	} front_state_t;

	front_state_t state_q;
	logic [15:0]  window_q;
	logic [8:0]   count_q;
	logic [15:0]  sum_q;
	logic [7:0]   dest_q;
	logic [7:0]   type_q;
	logic [7:0]   len_q;
	logic [7:0]   trailer_low_q;

	logic         accept;
	logic         sync_hit;
	logic [8:0]   pay_end;
	logic         in_header;
	logic         in_payload;
	logic         at_trailer_low;
	logic [8:0]   index_wide;

	assign s_tready       = !queue_full;
	assign accept         = s_tvalid && s_tready;
	assign sync_hit       = (window_q[7:0] == cfg.sync_first) && (s_tdata == cfg.sync_second);
	assign pay_end        = 9'(HdrLen) + {1'b0, len_q};
	assign in_header      = count_q < 9'(HdrLen);
	assign in_payload     = !in_header && (count_q < pay_end);
	assign at_trailer_low = !in_header && (count_q == pay_end);
	assign index_wide     = count_q - 9'(HdrLen);

	always_comb begin
		push_valid                = 1'b0;
		push_entry.frame_end      = 1'b0;
		push_entry.payload_byte   = s_tdata;
		push_entry.payload_index  = index_wide[7:0];
		push_entry.frame_type     = type_q;
		push_entry.destination    = dest_q;
		push_entry.payload_length = len_q;
		push_entry.trailer        = {s_tdata, trailer_low_q};
		push_entry.byte_sum       = sum_q;
		if (accept && state_q == ST_FRAME && !in_header) begin
			if (in_payload) begin
				push_valid = 1'b1;
			end else if (!at_trailer_low) begin
				push_valid           = 1'b1;
				push_entry.frame_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_HUNT;
			window_q      <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			dest_q        <= '0;
			type_q        <= '0;
			len_q         <= '0;
			trailer_low_q <= '0;
		end else if (accept) begin
			case (state_q)
				ST_HUNT: begin
					window_q <= {window_q[7:0], s_tdata};
					if (sync_hit) begin
						state_q       <= ST_FRAME;
						count_q       <= 9'd2;
						sum_q         <= {8'd0, cfg.sync_first} + {8'd0, cfg.sync_second};
						dest_q        <= '0;
						type_q        <= '0;
						len_q         <= '0;
						trailer_low_q <= '0;
					end
				end
				ST_FRAME: begin
					count_q <= count_q + 9'd1;
					if (in_header) begin
						case (count_q)
							9'd2:    dest_q <= s_tdata;
							9'd3:    type_q <= s_tdata;
							default: len_q  <= s_tdata;
						endcase
						sum_q <= sum_q + {8'd0, s_tdata};
					end else if (in_payload) begin
						sum_q <= sum_q + {8'd0, s_tdata};
					end else if (at_trailer_low) begin
						trailer_low_q <= s_tdata;
					end else begin
						// trailer high byte closes the frame
						state_q <= ST_HUNT;
						count_q <= '0;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

endmodule

[design/shfr_queue.sv]
// ----------------------------------------------------------------------------
// shfr_queue
// Two-entry result queue between the front and the back.
// ----------------------------------------------------------------------------
module shfr_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push_valid,
	input  shfr_pkg::result_entry_t   push_entry,
	output logic                      pop_valid,
	input  logic                      pop_ready,
	output shfr_pkg::result_entry_t   pop_entry,
	output shfr_pkg::queue_status_t   status
);
	import shfr_pkg::*;

	result_entry_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    level_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = level_q == 2'd2;
	assign status.level = level_q;
	assign pop_valid    = level_q != 2'd0;
	assign pop_entry    = mem_q[rd_ptr_q];
	assign do_push      = push_valid && !status.full;
	assign do_pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

[design/shfr_back.sv]
// ----------------------------------------------------------------------------
// shfr_back
// Take result entries from the queue, check the trailer against the byte
// sum on a frame end, and hold the packed word in the output register.
// ----------------------------------------------------------------------------
module shfr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  shfr_pkg::result_entry_t pop_entry,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [shfr_pkg::OutDataW-1:0] m_tdata,
	output logic                    m_tlast
);
	import shfr_pkg::*;

	logic                valid_q;
	logic [OutDataW-1:0] data_q;
	logic                last_q;
	logic                ok;
	logic [7:0]          byte_out;
	logic [7:0]          index_out;

	assign pop_ready = !valid_q || m_tready;
	assign ok        = pop_entry.frame_end && (pop_entry.trailer == pop_entry.byte_sum);
	assign byte_out  = pop_entry.frame_end ? 8'd0 : pop_entry.payload_byte;
	assign index_out = pop_entry.frame_end ? 8'd0 : pop_entry.payload_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			last_q <= pop_entry.frame_end;
			data_q <= {7'd0, ok, pop_entry.payload_length, pop_entry.destination,
				pop_entry.frame_type, index_out, byte_out};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

[design/sync_header_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// sync_header_frame_receiver_unit
// Deframer for sync-headed, length-prefixed link frames with a 16-bit sum.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received link bytes on the s_ channel, one word per byte. The unit
//   hunts for the two sync bytes set through the configuration port, then
//   reads destination, type and length, forwards each payload byte as one
//   m_ word, and closes every frame with one end word (m_tlast high) that
//   carries checksum_ok: the 16-bit wrapping sum of header and payload
//   against the little-endian trailer.
//   Throughput: one byte per cycle, sustained, as long as m_tready is high.
//   Path: the front classifies the byte that causes a result and pushes it into
//   the queue on the edge that takes that byte; the back then registers it into
//   the output register that drives m_tvalid.
//   Stall: when m_tready drops the output register holds its word, the
//   two-entry queue fills, and s_tready falls once the queue is full.
//   Reset: both sync registers and the sync window clear to zero, the
//   unit hunts, and queue and output register are empty.
//   Configure only while idle; an index with no register is ignored.
// ----------------------------------------------------------------------------
module sync_header_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// received bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] payload_byte, [15:8] payload_index, [23:16] frame_type,
	// [31:24] destination, [39:32] payload_length, [40] checksum_ok
	output logic [47:0] m_tdata,
	output logic        m_tlast    // kind: high on the frame end word
);
	import shfr_pkg::*;

	sync_cfg_t     cfg_q;
	logic          push_valid;
	result_entry_t push_entry;
	logic          pop_valid;
	logic          pop_ready;
	result_entry_t pop_entry;
	queue_status_t q_status;

	// sync registers: written any time, used by later sync detection and to seed the byte sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data;
				CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// front: hunt, parse and sum
	shfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (q_status.full),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// decouple front and back
	shfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	// back: checksum compare and output register
	shfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// a result is never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !q_status.full)
		else $error("result pushed into full queue");

	// input backpressure only comes from a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_status.level == 2'd2)
		else $error("s_tready low without full queue");

	// payload words never carry a checksum flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !m_tdata[40])
		else $error("checksum flag set on payload word");

	// a stalled output word with a full queue keeps the input blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && q_status.full) |=> !s_tready)
		else $error("input accepted while output and queue stalled");

endmodule
